[sv/kbd_pkg.sv]
// Package for the scancode decoder: set-1 key tables, dead-key codes and the
// Latin-1 composition function. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package kbd_pkg;

    // Set-1 make codes with a role of their own
    localparam logic [7:0] SC_LSHIFT   = 8'h2A;
    localparam logic [7:0] SC_RSHIFT   = 8'h36;
    localparam logic [7:0] SC_CAPS     = 8'h3A;
    localparam logic [7:0] SC_LAST     = 8'd57;
    localparam logic [7:0] SC_RELEASE  = 8'h80;
    localparam logic [6:0] SC_KEY_MASK = 7'h7F;

    // Controller status bits
    localparam int unsigned ST_OUT_FULL = 0;
    localparam int unsigned ST_AUX_DATA = 5;

    localparam logic [7:0] CASE_OFFSET = 8'h20;
    localparam logic [7:0] CH_LOW_A    = 8'h61;
    localparam logic [7:0] CH_LOW_Z    = 8'h7A;

    typedef enum logic [2:0] {
        ACC_NONE  = 3'd0,
        ACC_ACUTE = 3'd1,
        ACC_TILDE = 3'd2,
        ACC_CIRC  = 3'd3,
        ACC_GRAVE = 3'd4
    } accent_t;

    // Unshifted set-1 table, codes 0 to 57
    function automatic logic [7:0] plain_char(input logic [5:0] idx);
        logic [7:0] c;
        case (idx)
            6'd1:  c = 8'h1B;
            6'd2:  c = 8'h31;
            6'd3:  c = 8'h32;
            6'd4:  c = 8'h33;
            6'd5:  c = 8'h34;
            6'd6:  c = 8'h35;
            6'd7:  c = 8'h36;
            6'd8:  c = 8'h37;
            6'd9:  c = 8'h38;
            6'd10: c = 8'h39;
            6'd11: c = 8'h30;
            6'd12: c = 8'h2D;
            6'd13: c = 8'h3D;
            6'd14: c = 8'h08;
            6'd15: c = 8'h09;
            6'd16: c = 8'h71;
            6'd17: c = 8'h77;
            6'd18: c = 8'h65;
            6'd19: c = 8'h72;
            6'd20: c = 8'h74;
            6'd21: c = 8'h79;
            6'd22: c = 8'h75;
            6'd23: c = 8'h69;
            6'd24: c = 8'h6F;
            6'd25: c = 8'h70;
            6'd26: c = 8'h5B;
            6'd27: c = 8'h5D;
            6'd28: c = 8'h0A;
            6'd30: c = 8'h61;
            6'd31: c = 8'h73;
            6'd32: c = 8'h64;
            6'd33: c = 8'h66;
            6'd34: c = 8'h67;
            6'd35: c = 8'h68;
            6'd36: c = 8'h6A;
            6'd37: c = 8'h6B;
            6'd38: c = 8'h6C;
            6'd39: c = 8'h3B;
            6'd40: c = 8'h27;
            6'd41: c = 8'h60;
            6'd43: c = 8'h5C;
            6'd44: c = 8'h7A;
            6'd45: c = 8'h78;
            6'd46: c = 8'h63;
            6'd47: c = 8'h76;
            6'd48: c = 8'h62;
            6'd49: c = 8'h6E;
            6'd50: c = 8'h6D;
            6'd51: c = 8'h2C;
            6'd52: c = 8'h2E;
            6'd53: c = 8'h2F;
            6'd55: c = 8'h2A;
            6'd57: c = 8'h20;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // Shifted table: letters take their capital, symbol keys their upper legend
    function automatic logic [7:0] shifted_char(input logic [5:0] idx);
        logic [7:0] p;
        logic [7:0] c;
        p = plain_char(idx);
        case (idx)
            6'd2:  c = 8'h21;
            6'd3:  c = 8'h40;
            6'd4:  c = 8'h23;
            6'd5:  c = 8'h24;
            6'd6:  c = 8'h25;
            6'd7:  c = 8'h5E;
            6'd8:  c = 8'h26;
            6'd9:  c = 8'h2A;
            6'd10: c = 8'h28;
            6'd11: c = 8'h29;
            6'd12: c = 8'h5F;
            6'd13: c = 8'h2B;
            6'd26: c = 8'h7B;
            6'd27: c = 8'h7D;
            6'd39: c = 8'h3A;
            6'd40: c = 8'h22;
            6'd41: c = 8'h7E;
            6'd43: c = 8'h7C;
            6'd51: c = 8'h3C;
            6'd52: c = 8'h3E;
            6'd53: c = 8'h3F;
            default: begin
                if (p >= CH_LOW_A && p <= CH_LOW_Z) c = p - CASE_OFFSET;
                else                                 c = p;
            end
        endcase
        return c;
    endfunction

    function automatic accent_t accent_of(input logic [7:0] c);
        accent_t a;
        case (c)
            8'h27:   a = ACC_ACUTE;
            8'h7E:   a = ACC_TILDE;
            8'h5E:   a = ACC_CIRC;
            8'h60:   a = ACC_GRAVE;
            default: a = ACC_NONE;
        endcase
        return a;
    endfunction

    function automatic logic [7:0] accent_char(input accent_t a);
        logic [7:0] c;
        case (a)
            ACC_ACUTE: c = 8'h27;
            ACC_TILDE: c = 8'h7E;
            ACC_CIRC:  c = 8'h5E;
            ACC_GRAVE: c = 8'h60;
            default:   c = 8'h00;
        endcase
        return c;
    endfunction

    // Latin-1 accented form, or the base character unchanged
    function automatic logic [7:0] compose(input accent_t a, input logic [7:0] b);
        logic [7:0] c;
        c = b;
        case (a)
            ACC_ACUTE: begin
                case (b)
                    8'h61:   c = 8'd225;
                    8'h65:   c = 8'd233;
                    8'h69:   c = 8'd237;
                    8'h6F:   c = 8'd243;
                    8'h75:   c = 8'd250;
                    8'h63:   c = 8'd231;
                    default: c = b;
                endcase
            end
            ACC_TILDE: begin
                case (b)
                    8'h61:   c = 8'd227;
                    8'h6F:   c = 8'd245;
                    default: c = b;
                endcase
            end
            ACC_CIRC: begin
                case (b)
                    8'h61:   c = 8'd226;
                    8'h65:   c = 8'd234;
                    8'h6F:   c = 8'd244;
                    default: c = b;
                endcase
            end
            ACC_GRAVE: begin
                if (b == 8'h61) c = 8'd224;
                else            c = b;
            end
            default: c = b;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

[sv/keyboard_scancode_decoder_core.sv]
// Scancode set-1 to Latin-1 decoder with shift, caps lock and dead keys.
// Depends on kbd_pkg for the key tables and the composition function.
//
//  channel | ports                                  | direction | role
//  --------+----------------------------------------+-----------+----------------------------
//  s_      | s_valid s_ready s_ctrl_status          | in        | status and scancode byte
//          | s_scan_byte                            |           |
//  m_      | m_valid m_ready m_char_valid           | out       | one result item per input
//          | m_char_code m_dead_pending             |           |
//
// Each input item gives exactly one result item. It sits in the input
// register while the lookup, compose and flag update run, and moves into the
// result register, which drives m_valid, once that register is empty or
// draining. A new item may be taken every cycle; a stall on m_ready holds
// both stages and drops s_ready only once the input register is full too.
// Synchronous active-low reset empties both stages and clears shift, caps
// and the armed dead key.
`timescale 1ns / 1ps
`default_nettype none

module keyboard_scancode_decoder_core
    import kbd_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_ctrl_status,
    input  wire logic [7:0] s_scan_byte,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic            m_char_valid,
    output logic [7:0]      m_char_code,
    output logic            m_dead_pending
);

    // Input register
    logic       in_valid_reg;
    logic [7:0] status_reg;
    logic [7:0] scan_reg;

    // Result register
    logic       out_valid_reg;
    logic       char_valid_reg;
    logic [7:0] char_code_reg;
    logic       dead_pending_reg;

    // Decoder state
    logic       shift_held_reg;
    logic       caps_on_reg;
    accent_t    pending_accent_reg;

    logic       shift_held_next;
    logic       caps_on_next;
    accent_t    pending_accent_next;
    logic       char_valid_next;
    logic [7:0] char_code_next;

    logic       advance;
    logic       item_used;
    logic [7:0] key_char;
    logic [7:0] cased_char;
    accent_t    key_accent;

    // Move the input item on whenever the result register is empty or draining
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_ready && s_valid) begin
            status_reg <= s_ctrl_status;
            scan_reg   <= s_scan_byte;
        end
    end

    // Table lookup and caps handling; caps only uppercases when shift is up
    always_comb begin
        key_char = 8'h00;
        if (scan_reg <= SC_LAST) begin
            key_char = shift_held_reg ? shifted_char(scan_reg[5:0])
                                      : plain_char(scan_reg[5:0]);
        end
        cased_char = key_char;
        if (!shift_held_reg && caps_on_reg && key_char >= CH_LOW_A && key_char <= CH_LOW_Z) begin
            cased_char = key_char - CASE_OFFSET;
        end
        key_accent = accent_of(cased_char);
    end

    assign item_used = status_reg[ST_OUT_FULL] && !status_reg[ST_AUX_DATA];

    // Flag update and dead-key composition
    always_comb begin
        shift_held_next     = shift_held_reg;
        caps_on_next        = caps_on_reg;
        pending_accent_next = pending_accent_reg;
        char_valid_next     = 1'b0;
        char_code_next      = 8'h00;
        if (item_used) begin
            if ((scan_reg & SC_RELEASE) != 8'h00) begin
                // Only a shift release acts; every other break or prefix is dropped
                if ({1'b0, scan_reg[6:0] & SC_KEY_MASK} == SC_LSHIFT ||
                    {1'b0, scan_reg[6:0] & SC_KEY_MASK} == SC_RSHIFT) begin
                    shift_held_next = 1'b0;
                end
            end else if (scan_reg == SC_LSHIFT || scan_reg == SC_RSHIFT) begin
                shift_held_next = 1'b1;
            end else if (scan_reg == SC_CAPS) begin
                caps_on_next = !caps_on_reg;
            end else if (key_accent != ACC_NONE) begin
                if (pending_accent_reg == ACC_NONE) begin
                    pending_accent_next = key_accent;
                end else if (pending_accent_reg == key_accent) begin
                    // Same dead key twice: emit the accent itself and disarm
                    char_valid_next     = 1'b1;
                    char_code_next      = accent_char(key_accent);
                    pending_accent_next = ACC_NONE;
                end
                // A different dead key leaves the first armed
            end else if (cased_char != 8'h00) begin
                char_valid_next     = 1'b1;
                char_code_next      = compose(pending_accent_reg, cased_char);
                pending_accent_next = ACC_NONE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg      <= 1'b0;
            shift_held_reg     <= 1'b0;
            caps_on_reg        <= 1'b0;
            pending_accent_reg <= ACC_NONE;
        end else begin
            if (advance) begin
                out_valid_reg      <= 1'b1;
                shift_held_reg     <= shift_held_next;
                caps_on_reg        <= caps_on_next;
                pending_accent_reg <= pending_accent_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
        if (advance) begin
            char_valid_reg   <= char_valid_next;
            char_code_reg    <= char_code_next;
            dead_pending_reg <= (pending_accent_next != ACC_NONE);
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_char_valid   = char_valid_reg;
    assign m_char_code    = char_code_reg;
    assign m_dead_pending = dead_pending_reg;

endmodule

`default_nettype wire

[verif/tb.sv]
// Self-checking testbench for keyboard_scancode_decoder_core: scancode set-1
// items in, Latin-1 character items out, checked against an in-bench decoder.
// Depends on kbd_pkg for the accent enum and the key and status constants.
`timescale 1ns / 1ps

module tb;
    import kbd_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_ITEMS  = 1750;
    localparam int DRAIN_EVERY   = 600;   // sender waits for an empty pipe this often
    localparam int LONG_HOLD_AT  = 900;   // accepted items before the long receiver stall
    localparam int LONG_HOLD_LEN = 400;

    // Status masks built from the controller bit positions
    localparam logic [7:0] FULL_MASK = 8'h01 << ST_OUT_FULL;
    localparam logic [7:0] AUX_MASK  = 8'h01 << ST_AUX_DATA;

    // Set-1 make codes used by the stimulus
    localparam logic [7:0] KEY_ZERO_ENTRY = 8'h00;
    localparam logic [7:0] KEY_6          = 8'h07;  // ^ when shifted
    localparam logic [7:0] KEY_Q          = 8'h10;
    localparam logic [7:0] KEY_E          = 8'h12;
    localparam logic [7:0] KEY_U          = 8'h16;
    localparam logic [7:0] KEY_I          = 8'h17;
    localparam logic [7:0] KEY_O          = 8'h18;
    localparam logic [7:0] KEY_LCTRL      = 8'h1D;  // empty table entry
    localparam logic [7:0] KEY_A          = 8'h1E;
    localparam logic [7:0] KEY_QUOTE      = 8'h28;  // ' and "
    localparam logic [7:0] KEY_BACKTICK   = 8'h29;  // ` and ~
    localparam logic [7:0] KEY_C          = 8'h2E;
    localparam logic [7:0] KEY_F1         = 8'h3B;  // a code past the table
    localparam logic [7:0] KEY_TOP        = 8'h7F;
    localparam logic [7:0] KEY_PREFIX_E0  = 8'hE0;
    localparam logic [7:0] KEY_MAX        = 8'hFF;

    // Key maps, code 0 in the top byte and code 57 in the bottom byte
    localparam logic [58*8-1:0] LOWER_KEYMAP = {
        128'h001B_3132_3334_3536_3738_3930_2D3D_0809,
        112'h7177_6572_7479_7569_6F70_5B5D_0A00,
        112'h6173_6466_6768_6A6B_6C3B_2760_005C,
        112'h7A78_6376_626E_6D2C_2E2F_002A_0020
    };
    localparam logic [58*8-1:0] UPPER_KEYMAP = {
        128'h001B_2140_2324_255E_262A_2829_5F2B_0809,
        112'h5157_4552_5459_5549_4F50_7B7D_0A00,
        112'h4153_4446_4748_4A4B_4C3A_227E_007C,
        112'h5A58_4356_424E_4D3C_3E3F_002A_0020
    };

    typedef struct {
        logic [7:0] status;
        logic [7:0] scan;
        bit         hold_for_drain;
    } keystroke_t;

    typedef struct {
        logic       char_valid;
        logic [7:0] char_code;
        logic       dead_pending;
    } char_item_t;

    logic       aclk           = 1'b0;
    logic       aresetn        = 1'b0;
    logic       s_valid        = 1'b0;
    logic       s_ready;
    logic [7:0] s_ctrl_status  = 8'h00;
    logic [7:0] s_scan_byte    = 8'h00;
    logic       m_valid;
    logic       m_ready        = 1'b0;
    logic       m_char_valid;
    logic [7:0] m_char_code;
    logic       m_dead_pending;

    keystroke_t keystroke_q[$];      // items still to be offered
    char_item_t awaited_chars[$];    // decoded characters not yet seen on m_

    // Decoder state as the bench sees it
    logic    kb_shift;
    logic    kb_caps;
    accent_t kb_accent;

    int n_errors   = 0;
    int n_accepted = 0;
    int n_cycles   = 0;

    keyboard_scancode_decoder_core i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_ctrl_status  (s_ctrl_status),
        .s_scan_byte    (s_scan_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_char_valid   (m_char_valid),
        .m_char_code    (m_char_code),
        .m_dead_pending (m_dead_pending)
    );

    always #2 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Decoder in bench terms
    // ------------------------------------------------------------------
    function automatic accent_t dead_accent_of(input logic [7:0] ch);
        case (ch)
            8'h27:   return ACC_ACUTE;
            8'h7E:   return ACC_TILDE;
            8'h5E:   return ACC_CIRC;
            8'h60:   return ACC_GRAVE;
            default: return ACC_NONE;
        endcase
    endfunction

    function automatic logic [7:0] accent_glyph(input accent_t acc);
        case (acc)
            ACC_ACUTE: return 8'h27;
            ACC_TILDE: return 8'h7E;
            ACC_CIRC:  return 8'h5E;
            ACC_GRAVE: return 8'h60;
            default:   return 8'h00;
        endcase
    endfunction

    // Accented Latin-1 letter, or the base character when no form exists
    function automatic logic [7:0] latin1_compose(input accent_t acc, input logic [7:0] base);
        case ({acc, base})
            {ACC_ACUTE, 8'h61}: return 8'hE1;
            {ACC_ACUTE, 8'h65}: return 8'hE9;
            {ACC_ACUTE, 8'h69}: return 8'hED;
            {ACC_ACUTE, 8'h6F}: return 8'hF3;
            {ACC_ACUTE, 8'h75}: return 8'hFA;
            {ACC_ACUTE, 8'h63}: return 8'hE7;
            {ACC_TILDE, 8'h61}: return 8'hE3;
            {ACC_TILDE, 8'h6F}: return 8'hF5;
            {ACC_CIRC,  8'h61}: return 8'hE2;
            {ACC_CIRC,  8'h65}: return 8'hEA;
            {ACC_CIRC,  8'h6F}: return 8'hF4;
            {ACC_GRAVE, 8'h61}: return 8'hE0;
            default:            return base;
        endcase
    endfunction

    // Advance the bench state by one accepted item and queue the character
    // item that the block must return for it.
    task automatic decode_keystroke(input logic [7:0] status, input logic [7:0] scan);
        logic [7:0] ch;
        logic [7:0] key;
        accent_t    acc;
        char_item_t r;
        r.char_valid = 1'b0;
        r.char_code  = 8'h00;
        if (status[ST_OUT_FULL] && !status[ST_AUX_DATA]) begin
            key = {1'b0, scan[6:0] & SC_KEY_MASK};
            if ((scan & SC_RELEASE) != 8'h00) begin
                // only a shift release has any effect
                if (key == SC_LSHIFT || key == SC_RSHIFT) kb_shift = 1'b0;
            end else if (scan == SC_LSHIFT || scan == SC_RSHIFT) begin
                kb_shift = 1'b1;
            end else if (scan == SC_CAPS) begin
                kb_caps = ~kb_caps;
            end else begin
                ch = 8'h00;
                if (scan <= SC_LAST) begin
                    if (kb_shift) ch = UPPER_KEYMAP[(int'(SC_LAST) - int'(scan)) * 8 +: 8];
                    else          ch = LOWER_KEYMAP[(int'(SC_LAST) - int'(scan)) * 8 +: 8];
                end
                if (!kb_shift && kb_caps && ch >= CH_LOW_A && ch <= CH_LOW_Z)
                    ch = ch - CASE_OFFSET;
                acc = dead_accent_of(ch);
                if (acc != ACC_NONE) begin
                    // arm, emit on a repeat, ignore a different dead key
                    if (kb_accent == ACC_NONE) begin
                        kb_accent = acc;
                    end else if (kb_accent == acc) begin
                        r.char_valid = 1'b1;
                        r.char_code  = accent_glyph(acc);
                        kb_accent    = ACC_NONE;
                    end
                end else if (ch != 8'h00) begin
                    r.char_valid = 1'b1;
                    r.char_code  = latin1_compose(kb_accent, ch);
                    kb_accent    = ACC_NONE;
                end
            end
        end
        r.dead_pending = (kb_accent != ACC_NONE);
        awaited_chars.push_back(r);
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic queue_key(input logic [7:0] status, input logic [7:0] scan);
        keystroke_t k;
        k.status         = status;
        k.scan           = scan;
        k.hold_for_drain = 1'b0;
        keystroke_q.push_back(k);
    endtask

    // Mostly plausible typing: keys, dead keys, vowels and shift pairs, with
    // a share of rejected status bytes, stray releases and raw noise.
    function automatic keystroke_t random_keystroke();
        keystroke_t k;
        int         pick;
        k.hold_for_drain = 1'b0;
        if ($urandom_range(0, 99) < 85) k.status = (8'($urandom) | FULL_MASK) & ~AUX_MASK;
        else                            k.status = 8'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
            k.scan = 8'($urandom_range(0, int'(SC_LAST)));
        end else if (pick < 50) begin
            case ($urandom_range(0, 2))
                0:       k.scan = KEY_QUOTE;
                1:       k.scan = KEY_BACKTICK;
                default: k.scan = KEY_6;
            endcase
        end else if (pick < 62) begin
            case ($urandom_range(0, 5))
                0:       k.scan = KEY_A;
                1:       k.scan = KEY_E;
                2:       k.scan = KEY_I;
                3:       k.scan = KEY_O;
                4:       k.scan = KEY_U;
                default: k.scan = KEY_C;
            endcase
        end else if (pick < 72) begin
            k.scan = $urandom_range(0, 1) ? SC_LSHIFT : SC_RSHIFT;
        end else if (pick < 82) begin
            k.scan = ($urandom_range(0, 1) ? SC_LSHIFT : SC_RSHIFT) | SC_RELEASE;
        end else if (pick < 85) begin
            k.scan = SC_CAPS;
        end else if (pick < 92) begin
            k.scan = 8'($urandom_range(int'(SC_RELEASE), int'(KEY_MAX)));
        end else begin
            k.scan = 8'($urandom);
        end
        return k;
    endfunction

    // ------------------------------------------------------------------
    // Driver: offer queued items in bursts, predict on acceptance
    // ------------------------------------------------------------------
    int         gap_left;
    int         burst_left;
    logic       offer_next;
    keystroke_t next_key;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid    <= 1'b0;
            gap_left   = 0;
            burst_left = 0;
            kb_shift   = 1'b0;
            kb_caps    = 1'b0;
            kb_accent  = ACC_NONE;
        end else begin
            offer_next = s_valid;
            if (s_valid && s_ready) begin
                decode_keystroke(s_ctrl_status, s_scan_byte);
                n_accepted++;
                offer_next = 1'b0;
            end
            // Load the next item straight away unless a gap is running or
            // the item asks for an empty pipe first; valid is set only once.
            if (!offer_next && keystroke_q.size() != 0) begin
                if (gap_left != 0) begin
                    gap_left--;
                end else if (!keystroke_q[0].hold_for_drain || awaited_chars.size() == 0) begin
                    next_key = keystroke_q.pop_front();
                    s_ctrl_status <= next_key.status;
                    s_scan_byte   <= next_key.scan;
                    offer_next = 1'b1;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 48);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
                    end
                end
            end
            s_valid <= offer_next;
        end
    end

    // ------------------------------------------------------------------
    // Receiver back-pressure: a rotating pattern, plus one long hold-off
    // once enough items are in so the block fills and drops s_ready
    // ------------------------------------------------------------------
    logic [7:0] rdy_phase;
    int         hold_left;
    bit         long_hold_done;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready        <= 1'b0;
            rdy_phase      <= 8'd0;
            hold_left      <= 0;
            long_hold_done <= 1'b0;
        end else if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!long_hold_done && n_accepted >= LONG_HOLD_AT) begin
            m_ready        <= 1'b0;
            hold_left      <= LONG_HOLD_LEN;
            long_hold_done <= 1'b1;
        end else begin
            rdy_phase <= rdy_phase + 8'd1;
            case (rdy_phase[7:6])
                2'd0:    m_ready <= 1'b1;
                2'd1:    m_ready <= 1'($urandom_range(0, 1));
                2'd2:    m_ready <= ($urandom_range(0, 3) == 0);
                default: m_ready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare every accepted character item with the oldest one due
    // ------------------------------------------------------------------
    char_item_t due_char;

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (awaited_chars.size() == 0) begin
                $error("result item with nothing awaited: valid=%0d code=%02h dead=%0d",
                       m_char_valid, m_char_code, m_dead_pending);
                n_errors++;
            end else begin
                due_char = awaited_chars.pop_front();
                if (m_char_valid !== due_char.char_valid) begin
                    $error("m_char_valid: expected %0d, got %0d", due_char.char_valid, m_char_valid);
                    n_errors++;
                end
                if (m_char_code !== due_char.char_code) begin
                    $error("m_char_code: expected %02h, got %02h", due_char.char_code, m_char_code);
                    n_errors++;
                end
                if (m_dead_pending !== due_char.dead_pending) begin
                    $error("m_dead_pending: expected %0d, got %0d",
                           due_char.dead_pending, m_dead_pending);
                    n_errors++;
                end
            end
        end
    end

    // Guard against a hung handshake
    always @(posedge aclk) begin
        n_cycles++;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence: fill the item queue, release reset, wait for the drain
    // ------------------------------------------------------------------
    initial begin
        keystroke_t k;
        int         n;
        // Rejected status bytes, then extremes of both fields
        queue_key(8'h00, KEY_A);                       // output not full
        queue_key(FULL_MASK | AUX_MASK, KEY_A);        // mouse data
        queue_key(KEY_MAX, KEY_MAX);                   // all bits set, aux wins
        queue_key(~AUX_MASK, KEY_A);                   // usable with every other bit set
        // Dead keys: repeat emits, a different one is ignored, then compose
        queue_key(FULL_MASK, KEY_QUOTE);
        queue_key(FULL_MASK, KEY_QUOTE);
        queue_key(FULL_MASK, KEY_QUOTE);
        queue_key(FULL_MASK, KEY_BACKTICK);
        queue_key(FULL_MASK, KEY_A);
        // Shifted tilde over o, with both shift keys and a release
        queue_key(FULL_MASK, SC_LSHIFT);
        queue_key(FULL_MASK, KEY_BACKTICK);
        queue_key(FULL_MASK, SC_RSHIFT);
        queue_key(FULL_MASK, SC_LSHIFT | SC_RELEASE);
        queue_key(FULL_MASK, KEY_O);
        // Circumflex stays armed over empty entries, codes past the table
        // and non-shift releases, then meets a capital with no accented form
        queue_key(FULL_MASK, SC_RSHIFT);
        queue_key(FULL_MASK, KEY_6);
        queue_key(FULL_MASK, SC_RSHIFT | SC_RELEASE);
        queue_key(FULL_MASK, KEY_F1);
        queue_key(FULL_MASK, KEY_LCTRL);
        queue_key(FULL_MASK, KEY_PREFIX_E0);
        queue_key(FULL_MASK, SC_CAPS);
        queue_key(FULL_MASK, KEY_E);
        queue_key(FULL_MASK, SC_CAPS);
        queue_key(FULL_MASK, KEY_ZERO_ENTRY);
        queue_key(FULL_MASK, KEY_TOP);
        queue_key(FULL_MASK, KEY_Q);

        for (n = 0; n < RANDOM_ITEMS; n++) begin
            k = random_keystroke();
            // hold the sender now and then until every character is back
            if (n % DRAIN_EVERY == DRAIN_EVERY - 1) k.hold_for_drain = 1'b1;
            keystroke_q.push_back(k);
        end

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        while (keystroke_q.size() != 0 || s_valid) @(posedge aclk);
        for (n = 0; n < 4000 && awaited_chars.size() != 0; n++) @(posedge aclk);
        repeat (8) @(posedge aclk);

        if (awaited_chars.size() != 0) begin
            $error("%0d character items never arrived", awaited_chars.size());
            n_errors++;
        end
        if (n_errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
